FILE: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: src/sip24_pkg.sv
package sip24_pkg;

    localparam int LANE_W = 64;
    localparam int LEN_W = 8;
    localparam int CNT_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [LANE_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [LANE_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [LANE_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [LANE_W-1:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [LANE_W-1:0] FINAL_XOR = 64'h00000000000000ff;

    localparam logic [CNT_W-1:0] FULL_WORD_BYTES = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] c;
        logic [LANE_W-1:0] d;
    } lanes_t;

    // One queued command per accepted request
    typedef struct packed {
        logic              start;
        logic              has_block;
        logic              has_final;
        logic [LANE_W-1:0] block_word;
        logic [LANE_W-1:0] final_word;
    } cmd_t;

    typedef struct packed {
        logic   active;
        logic   hash_done;
    } back_status_t;

    function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] x, input int n);
        return (x << n) | (x >> (LANE_W - n));
    endfunction

    function automatic lanes_t sip_round(input lanes_t v);
        lanes_t r;
        r = v;
        r.a = r.a + r.b; r.b = rotl(r.b, 13); r.b = r.b ^ r.a; r.a = rotl(r.a, 32);
        r.c = r.c + r.d; r.d = rotl(r.d, 16); r.d = r.d ^ r.c;
        r.a = r.a + r.d; r.d = rotl(r.d, 21); r.d = r.d ^ r.a;
        r.c = r.c + r.b; r.b = rotl(r.b, 17); r.b = r.b ^ r.c; r.c = rotl(r.c, 32);
        return r;
    endfunction

endpackage

FILE: src/siphash_2_4_keyed_hash_unit.sv
// SipHash-2-4 over a stream of little-endian 64-bit words under a 128-bit key.
// Write k0 and k1 through the cfg port while idle; the key is sampled when a
// message starts. Each request is one word: tlast marks the last word of a
// message, and on that word byte_count (0..8, larger values act as 8) gives the
// valid bytes. One hash comes out per message on m_axis after the last word.
// The front end accepts a request per cycle into a small command queue until
// the queue fills; the back end runs one SipRound per cycle in a single round
// unit while a command is queued, so a non-last word takes two SipRounds, a
// last word with 0..7 bytes takes six and a full last word takes eight. A
// finished hash sits in an output register; the back end keeps working and
// holds only at its final round if that register has not been taken yet.
`include "assert_macros.svh"

module siphash_2_4_keyed_hash_unit #(
    parameter int QUEUE_DEPTH = sip24_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write port
    input  logic                                cfg_we,
    input  logic [sip24_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sip24_pkg::LANE_W-1:0]        cfg_data,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [71:0]                         s_axis_tdata,  // data_word[63:0], byte_count[67:64], zero pad
    input  logic                                s_axis_tlast,
    // hash results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [63:0]                         m_axis_tdata   // hash_value[63:0]
);
    import sip24_pkg::*;

    logic [LANE_W-1:0] key_low_reg;
    logic [LANE_W-1:0] key_high_reg;

    logic         push;
    cmd_t         push_cmd;
    logic         queue_full;
    logic         pop;
    logic         head_valid;
    cmd_t         head;
    back_status_t status;

    // Key registers: take a write whenever the enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    // Front end: track message start and length, build the final block
    sip24_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_word  (s_axis_tdata[63:0]),
        .byte_count (s_axis_tdata[67:64]),
        .last_word  (s_axis_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue between the two halves
    sip24_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: round unit, lane state and output register
    sip24_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hash_value (m_axis_tdata),
        .status     (status)
    );

    `ASSERT_IMPL(a_pop_needs_entry, pop, head_valid)
    `ASSERT_IMPL(a_active_needs_entry, status.active, head_valid)
    `ASSERT_NEXT(a_push_fills_queue, s_axis_tvalid && s_axis_tready, head_valid)
    `ASSERT_NEXT(a_hash_reaches_output, status.hash_done, m_axis_tvalid)

endmodule

FILE: src/sip24_front.sv
module sip24_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sip24_pkg::LANE_W-1:0]    data_word,
    input  logic [sip24_pkg::CNT_W-1:0]     byte_count,
    input  logic                            last_word,
    input  logic                            queue_full,
    output logic                            push,
    output sip24_pkg::cmd_t                 push_cmd
);
    import sip24_pkg::*;

    logic             open_reg, open_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] len_base;
    logic [LEN_W-1:0] len_new;
    logic [CNT_W-1:0] cnt;
    logic [LANE_W-1:0] tail;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        len_base = open_reg ? length_reg : '0;
        cnt = (byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : byte_count;
        if (!last_word)
        begin
            len_new = len_base + LEN_W'(FULL_WORD_BYTES);
        end
        else
        begin
            len_new = len_base + LEN_W'(cnt);
        end
        // keep only the valid tail bytes
        for (int i = 0; i < 8; i++)
        begin
            tail[i*8 +: 8] = (CNT_W'(i) < cnt) ? data_word[i*8 +: 8] : 8'h00;
        end

        push_cmd.start      = !open_reg;
        push_cmd.has_block  = !last_word || (cnt == FULL_WORD_BYTES);
        push_cmd.has_final  = last_word;
        push_cmd.block_word = data_word;
        push_cmd.final_word = {len_new,
                               (cnt == FULL_WORD_BYTES) ? 56'h0 : tail[LANE_W-LEN_W-1:0]};

        open_next   = open_reg;
        length_next = length_reg;
        if (push)
        begin
            open_next   = !last_word;
            length_next = len_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            length_reg <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            length_reg <= length_next;
        end
    end

endmodule

FILE: src/sip24_queue.sv
module sip24_queue #(
    parameter int DEPTH = sip24_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sip24_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sip24_pkg::cmd_t head
);
    import sip24_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/sip24_back.sv
module sip24_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sip24_pkg::LANE_W-1:0]    key_low,
    input  logic [sip24_pkg::LANE_W-1:0]    key_high,
    input  logic                            head_valid,
    input  sip24_pkg::cmd_t                 head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sip24_pkg::LANE_W-1:0]    hash_value,
    output sip24_pkg::back_status_t         status
);
    import sip24_pkg::*;

    // One SipRound per phase
    typedef enum logic [2:0] {
        PH_BLOCK0,
        PH_BLOCK1,
        PH_FINAL0,
        PH_FINAL1,
        PH_ROUND0,
        PH_ROUND1,
        PH_ROUND2,
        PH_ROUND3
    } phase_t;

    lanes_t            lanes_reg, lanes_next;
    logic              active_reg, active_next;
    phase_t            phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [LANE_W-1:0] hash_reg, hash_next;

    phase_t            cur_phase;
    lanes_t            base;
    lanes_t            pre;
    lanes_t            post;
    logic              done;
    logic              advance;
    logic              hash_done;

    always_comb
    begin
        cur_phase = active_reg ? phase_reg : (head.has_block ? PH_BLOCK0 : PH_FINAL0);

        // load the lanes from the key when a message starts
        if (!active_reg && head.start)
        begin
            base.a = SIP_C0 ^ key_low;
            base.b = SIP_C1 ^ key_high;
            base.c = SIP_C2 ^ key_low;
            base.d = SIP_C3 ^ key_high;
        end
        else
        begin
            base = lanes_reg;
        end

        pre = base;
        case (cur_phase)
            PH_BLOCK0: pre.d = base.d ^ head.block_word;
            PH_FINAL0: pre.d = base.d ^ head.final_word;
            PH_ROUND0: pre.c = base.c ^ FINAL_XOR;
            default:   pre = base;
        endcase

        post = sip_round(pre);
        case (cur_phase)
            PH_BLOCK1: post.a = post.a ^ head.block_word;
            PH_FINAL1: post.a = post.a ^ head.final_word;
            default:   post.a = post.a;
        endcase

        done      = ((cur_phase == PH_BLOCK1) && !head.has_final) || (cur_phase == PH_ROUND3);
        // hold the last round while the previous hash is still waiting
        advance   = head_valid && !((cur_phase == PH_ROUND3) && out_valid_reg && !out_ready);
        hash_done = advance && (cur_phase == PH_ROUND3);
        pop       = advance && done;

        lanes_next  = lanes_reg;
        active_next = active_reg;
        phase_next  = phase_reg;
        if (advance)
        begin
            lanes_next  = post;
            active_next = !done;
            phase_next  = phase_t'(cur_phase + 3'd1);
        end

        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;
        if (hash_done)
        begin
            out_valid_next = 1'b1;
            hash_next      = post.a ^ post.b ^ post.c ^ post.d;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_reg     <= '0;
            active_reg    <= 1'b0;
            phase_reg     <= PH_BLOCK0;
            out_valid_reg <= 1'b0;
            hash_reg      <= '0;
        end
        else
        begin
            lanes_reg     <= lanes_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hash_value       = hash_reg;
    assign status.active    = active_reg;
    assign status.hash_done = hash_done;

endmodule
